// ===== rtl/lzsd_pkg.sv =====
`timescale 1ns / 1ps

package lzsd_pkg;

  // Window geometry
  localparam int WIN_BITS = 12;
  localparam int WIN_SIZE = 1 << WIN_BITS;

  // Token format
  localparam int POS_BIAS  = 18;
  localparam int MIN_MATCH = 3;
  localparam int OFF_W     = 12;
  localparam int LEN_W     = 5;
  localparam int FLAG_CNT  = 8;

  // One decoded token handed from the parser to the copy engine
  typedef struct packed {
    logic             frame_clr;  // clear position and fill count before this beat
    logic             lit;        // literal byte in data
    logic             ref_go;     // start a back-reference copy
    logic [7:0]       data;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

// ===== rtl/lzsd_window_ram.sv =====
`timescale 1ns / 1ps

module lzsd_window_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lzsd_pkg::WIN_BITS-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [lzsd_pkg::WIN_BITS-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [lzsd_pkg::WIN_SIZE];

  // Read each cycle and write when we is set; a read of the entry being written returns the old byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lzsd_copy_engine.sv =====
`timescale 1ns / 1ps

module lzsd_copy_engine (
  input  logic           clk,
  input  logic           rst,
  input  lzsd_pkg::cmd_t cmd,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  localparam int WB = lzsd_pkg::WIN_BITS;

  logic                          copy;
  logic [WB-1:0]                 src;
  logic [WB-1:0]                 src_next;
  logic [WB-1:0]                 src_start;
  logic [WB-1:0]                 wp;
  logic [WB-1:0]                 wp_eff;
  logic [WB-1:0]                 offset_w;
  logic [WB-1:0]                 dist_low;
  logic [WB:0]                   src_dist;
  logic [WB:0]                   dist_start;
  logic [WB:0]                   fill;
  logic [WB:0]                   fill_eff;
  logic [WB:0]                   fill_inc;
  logic [lzsd_pkg::LEN_W-1:0]    cnt;
  logic                          out_free;
  logic                          emit_copy;
  logic                          we;
  logic [7:0]                    wdata;
  logic [7:0]                    rd_q;
  logic [7:0]                    fwd_data;
  logic                          fwd_hit;
  logic [7:0]                    copy_val;

  // Frame clear applies before the beat that carries it
  assign wp_eff   = cmd.frame_clr ? '0 : wp;
  assign fill_eff = cmd.frame_clr ? '0 : fill;
  assign fill_inc = (fill_eff == (WB+1)'(lzsd_pkg::WIN_SIZE)) ? fill_eff : fill_eff + 1'b1;

  // Source start and distance of a new reference; distance zero means a full window
  assign offset_w   = WB'(cmd.offset);
  assign src_start  = offset_w + WB'(lzsd_pkg::POS_BIAS);
  assign dist_low   = wp_eff - WB'(lzsd_pkg::POS_BIAS) - offset_w;
  assign dist_start = (dist_low == '0) ? (WB+1)'(lzsd_pkg::WIN_SIZE) : {1'b0, dist_low};

  // Output register is free when empty or being drained
  assign out_free  = !out_valid || out_ready;
  assign emit_copy = copy && out_free;
  assign ready     = !copy && out_free;

  // Source byte: zero before the stream start, forwarded when just written
  assign copy_val = (src_dist > fill) ? 8'h00 : (fwd_hit ? fwd_data : rd_q);

  assign we    = emit_copy || cmd.lit;
  assign wdata = copy ? copy_val : cmd.data;

  // Address the read at the source used in the next cycle
  always_comb begin
    if (cmd.ref_go) begin
      src_next = src_start;
    end else if (emit_copy) begin
      src_next = src + 1'b1;
    end else begin
      src_next = src;
    end
  end

  lzsd_window_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp_eff),
    .wdata (wdata),
    .raddr (src_next),
    .rdata (rd_q)
  );

  // Track a read that collides with the write in the same cycle
  always_ff @(posedge clk) begin
    fwd_hit  <= we && (wp_eff == src_next);
    fwd_data <= wdata;
    src      <= src_next;
    if (cmd.ref_go) begin
      src_dist <= dist_start;
    end
  end

  // Position, fill count and copy sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      copy <= 1'b0;
      cnt  <= '0;
      wp   <= '0;
      fill <= '0;
    end else begin
      if (we) begin
        wp   <= wp_eff + 1'b1;
        fill <= fill_inc;
      end else if (cmd.frame_clr) begin
        wp   <= '0;
        fill <= '0;
      end
      if (cmd.ref_go) begin
        copy <= 1'b1;
        cnt  <= cmd.len;
      end else if (emit_copy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lzsd_pkg::LEN_W'(1)) begin
          copy <= 1'b0;
        end
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (we) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      out_byte <= wdata;
      out_last <= copy ? (cnt == lzsd_pkg::LEN_W'(1)) : 1'b1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(we && out_valid && !out_ready))
    else $error("output beat overwritten while stalled");

  a_copy_start: assert property (@(posedge clk) disable iff (rst)
    cmd.ref_go |=> copy && (cnt >= lzsd_pkg::LEN_W'(lzsd_pkg::MIN_MATCH)))
    else $error("reference did not start a copy");

  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    (emit_copy && cnt == lzsd_pkg::LEN_W'(1)) |=> !copy && out_valid && out_last)
    else $error("copy did not end on its last beat");

  a_fill_sat: assert property (@(posedge clk) disable iff (rst)
    fill <= (WB+1)'(lzsd_pkg::WIN_SIZE))
    else $error("fill count beyond window size");

  a_no_cmd_in_copy: assert property (@(posedge clk) disable iff (rst)
    copy |-> !cmd.lit && !cmd.ref_go)
    else $error("token taken during a copy");

endmodule

// ===== rtl/lzss_stream_decoder_core.sv =====
`timescale 1ns / 1ps

// LZSS stream decoder: takes one compressed byte per input beat and emits the
// decompressed bytes, one per output beat, with tlast on the final byte that an
// input beat causes. A flag byte governs the next eight tokens, lowest bit first:
// a set bit is a literal, a clear bit a two-byte reference (12-bit offset, length
// 3 to 18) copied byte by byte from a 4096-byte history window held in one
// single-port-write RAM with a registered read. Every input beat waits for a
// free output register; a second reference byte starts a copy, and no input is
// taken until the copy ends. Every copied byte is one window read and one window
// write. tuser set on a beat starts a new frame: position, fill count and flag
// state are cleared before that byte, and references that reach before the frame
// start return zero bytes.
module lzss_stream_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // run_last
);

  logic                   accept;
  logic [7:0]             flag_bits;
  logic [3:0]             flag_left;
  logic                   pending;
  logic [7:0]             first_byte;
  logic [3:0]             left_eff;
  logic                   pending_eff;
  logic                   is_flag;
  logic                   is_lit;
  logic                   is_first;
  logic                   is_second;
  logic                   eng_ready;
  lzsd_pkg::cmd_t         cmd;

  assign s_axis_tready = eng_ready;
  assign accept        = s_axis_tvalid && eng_ready;

  // Classify the beat against the flag state, cleared first on a frame start
  assign left_eff    = s_axis_tuser ? 4'd0 : flag_left;
  assign pending_eff = s_axis_tuser ? 1'b0 : pending;
  assign is_flag     = (left_eff == 4'd0);
  assign is_lit      = !is_flag && flag_bits[0];
  assign is_first    = !is_flag && !flag_bits[0] && !pending_eff;
  assign is_second   = !is_flag && !flag_bits[0] && pending_eff;

  always_comb begin
    cmd           = '0;
    cmd.frame_clr = accept && s_axis_tuser;
    cmd.lit       = accept && is_lit;
    cmd.ref_go    = accept && is_second;
    cmd.data      = s_axis_tdata;
    cmd.offset    = {s_axis_tdata[7:4], first_byte};
    cmd.len       = lzsd_pkg::LEN_W'(s_axis_tdata[3:0]) + lzsd_pkg::LEN_W'(lzsd_pkg::MIN_MATCH);
  end

  // Flag and first reference byte state
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits  <= '0;
      flag_left  <= '0;
      pending    <= 1'b0;
      first_byte <= '0;
    end else if (accept) begin
      if (s_axis_tuser) begin
        pending    <= 1'b0;
        first_byte <= '0;
      end
      if (is_flag) begin
        flag_bits <= s_axis_tdata;
        flag_left <= 4'(lzsd_pkg::FLAG_CNT);
      end else if (is_first) begin
        first_byte <= s_axis_tdata;
        pending    <= 1'b1;
      end else begin
        flag_bits <= flag_bits >> 1;
        flag_left <= left_eff - 1'b1;
        pending   <= 1'b0;
      end
    end
  end

  lzsd_copy_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ready     (eng_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== sim/lzsd_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the decoder, predicts the decompressed bytes
// for every accepted input beat and checks each output beat against the oldest
// outstanding prediction.
module lzsd_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] frame_start
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tlast,   // run_last
  output int         fail_count,
  output int         bytes_owed
);

  import lzsd_pkg::*;

  localparam logic [WIN_BITS-1:0] BIAS      = WIN_BITS'(POS_BIAS);
  localparam logic [WIN_BITS:0]   FULL_DIST = (WIN_BITS+1)'(WIN_SIZE);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_beat_t;

  out_beat_t           owed_q[$];

  // Decoder state mirrored on the checker side
  logic [7:0]          window [WIN_SIZE];
  logic [WIN_BITS-1:0] wr_pos;
  logic [WIN_BITS:0]   filled;
  logic [7:0]          flag_reg;
  logic [3:0]          flags_left;
  logic                ref_open;
  logic [7:0]          ref_lo;

  int fails = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    fails++;
    $display("[%0t] lzsd check: %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic clear_frame();
    wr_pos     = '0;
    filled     = '0;
    flag_reg   = '0;
    flags_left = '0;
    ref_open   = 1'b0;
    ref_lo     = '0;
  endtask

  // Store one decoded byte in the history and queue it as owed output
  task automatic emit_byte(input logic [7:0] v, input logic last);
    out_beat_t e;
    e.value = v;
    e.last  = last;
    owed_q.push_back(e);
    window[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
    if (filled < FULL_DIST)
      filled = filled + 1'b1;
  endtask

  task automatic take_flag();
    flag_reg = flag_reg >> 1;
    if (flags_left != 0)
      flags_left = flags_left - 1'b1;
  endtask

  task automatic decode_beat(input logic [7:0] b, input logic fs);
    logic [WIN_BITS-1:0] off;
    logic [WIN_BITS-1:0] back;
    logic [WIN_BITS:0]   src_dist;
    logic [7:0]          v;
    int                  len;
    int                  k;
    if (fs)
      clear_frame();
    if (flags_left == 0) begin
      flag_reg   = b;
      flags_left = 4'(FLAG_CNT);
    end else if (flag_reg[0]) begin
      emit_byte(b, 1'b1);
      take_flag();
    end else if (!ref_open) begin
      ref_lo   = b;
      ref_open = 1'b1;
    end else begin
      len  = int'(b[3:0]) + MIN_MATCH;
      off  = {b[7:4], ref_lo};
      back = wr_pos - BIAS - off;
      // a zero distance reaches round the whole ring
      src_dist = (back == '0) ? FULL_DIST : {1'b0, back};
      ref_open = 1'b0;
      // copy byte by byte so that overlapping runs repeat fresh bytes
      for (k = 0; k < len; k++) begin
        v = (src_dist > filled) ? 8'h00 : window[wr_pos - src_dist[WIN_BITS-1:0]];
        emit_byte(v, k == len - 1);
      end
      take_flag();
    end
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      clear_frame();
      owed_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        decode_beat(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("output beat with nothing owed", m_tdata, 8'h00);
        end else begin
          want = owed_q.pop_front();
          if (m_tdata !== want.value)
            report_mismatch("out_byte", m_tdata, want.value);
          if (m_tlast !== want.last)
            report_mismatch("run_last", {7'b0, m_tlast}, {7'b0, want.last});
        end
      end
    end
    fail_count <= fails;
    bytes_owed <= owed_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Drives compressed streams into the decoder: a short directed frame set, then
// random well-formed frames with occasional broken ones, and one long frame
// that fills half the window with short references. Both channels idle at random.
module tb;

  import lzsd_pkg::*;

  localparam int                  STALL_LIMIT = 1000;
  localparam logic [WIN_BITS-1:0] BIAS        = WIN_BITS'(POS_BIAS);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tuser = 1'b0;    // [0] frame_start
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // run_last

  int fail_count;
  int bytes_owed;

  bit calm = 1'b0;     // no new idle stretch on either side while set
  int produced = 0;    // output bytes since the last frame start
  int sent = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  lzss_stream_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lzsd_stream_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int fill_now();
    return (produced > WIN_SIZE) ? WIN_SIZE : produced;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return MIN_MATCH;
    if (r < 40) return 18;
    return $urandom_range(MIN_MATCH, 18);
  endfunction

  // Distance back into the output; WIN_SIZE encodes as a zero distance
  function automatic int pick_dist();
    int f;
    int r;
    f = fill_now();
    r = $urandom_range(0, 99);
    if (f == 0) return $urandom_range(1, WIN_SIZE);
    if (r < 45) return $urandom_range(1, (f < 32) ? f : 32);
    if (r < 75) return $urandom_range(1, f);
    if (r < 85) return WIN_SIZE;
    if (f < WIN_SIZE - 1) return $urandom_range(f + 1, WIN_SIZE - 1);
    return $urandom_range(1, f);
  endfunction

  // Receiver side: hold tready low for random stretches
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= pause_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [7:0] d, input logic fs);
    int g;
    g = (calm || $urandom_range(0, 1) == 0) ? 0 : pause_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fs;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_flag(input logic [7:0] f, input logic fs);
    if (fs)
      produced = 0;
    send_beat(f, fs);
  endtask

  task automatic send_literal(input logic [7:0] b);
    send_beat(b, 1'b0);
    produced++;
  endtask

  task automatic send_ref_raw(input logic [WIN_BITS-1:0] off, input int len);
    logic [3:0] code;
    code = 4'(len - MIN_MATCH);
    send_beat(off[7:0], 1'b0);
    send_beat({off[11:8], code}, 1'b0);
    produced += len;
  endtask

  task automatic send_ref(input int span, input int len);
    logic [WIN_BITS-1:0] off;
    off = produced[WIN_BITS-1:0] - BIAS - span[WIN_BITS-1:0];
    send_ref_raw(off, len);
  endtask

  // One flag byte and its eight tokens; may break off part way through
  task automatic emit_group(input bit first, input bit fill_up, output bit broke);
    logic [7:0] fl;
    int         r;
    int         f;
    int         i;
    broke = 1'b0;
    calm = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (fill_up || r < 20)
      fl = 8'h00;
    else if (r < 35)
      fl = 8'hFF;
    else
      fl = 8'($urandom);
    send_flag(fl, first);
    for (i = 0; i < 8; i++) begin
      if (!fill_up && $urandom_range(0, 99) < 2) begin
        // leave a reference half sent, or just cut the group short
        if (!fl[i])
          send_beat(8'($urandom), 1'b0);
        broke = 1'b1;
        return;
      end
      f = fill_now();
      if (fl[i])
        send_literal(8'($urandom));
      else if (fill_up)
        send_ref((f == 0) ? 1 : $urandom_range(1, (f < 48) ? f : 48), 18);
      else
        send_ref(pick_dist(), pick_len());
    end
  endtask

  task automatic emit_frame(input int groups);
    bit broke;
    int g;
    for (g = 0; g < groups; g++) begin
      emit_group(g == 0, 1'b0, broke);
      if (broke)
        break;
    end
  endtask

  initial begin
    bit broke;
    int g;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All literals, byte extremes and alternating bits
    send_flag(8'hFF, 1'b1);
    send_literal(8'h00);
    send_literal(8'hFF);
    send_literal(8'hA5);
    send_literal(8'h5A);
    send_literal(8'h01);
    send_literal(8'h80);
    send_literal(8'h7F);
    send_literal(8'hFE);

    // All references: overlapping run, reach before the frame, zero distance,
    // the very first byte of the frame, and the largest offset
    send_flag(8'h00, 1'b0);
    send_ref(1, 18);
    send_ref(4000, MIN_MATCH);
    send_ref(WIN_SIZE, MIN_MATCH);
    send_ref(produced, MIN_MATCH);
    send_ref_raw('1, MIN_MATCH);

    // Cut a reference in half with a new frame; old history must read as zero
    send_beat(8'h3C, 1'b0);
    send_flag(8'h01, 1'b1);
    send_literal(8'h33);
    send_ref(2, MIN_MATCH);

    // Random frames, then one long frame, then more frames
    while (sent < 120)
      emit_frame($urandom_range(1, 6));
    emit_group(1'b1, 1'b1, broke);
    while (produced < WIN_SIZE / 2)
      emit_group(1'b0, 1'b1, broke);
    for (g = 0; g < 3; g++) begin
      emit_group(1'b0, 1'b0, broke);
      if (broke)
        break;
    end
    while (sent < 460)
      emit_frame($urandom_range(1, 6));
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline to settle
    calm = 1'b0;
    do @(posedge clk); while (bytes_owed != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lzsd_pkg.sv
rtl/lzsd_window_ram.sv
rtl/lzsd_copy_engine.sv
rtl/lzss_stream_decoder_core.sv
sim/lzsd_stream_checker.sv
sim/tb.sv
